[rtl/twfaw_pkg.sv]
package twfaw_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
        32'd128
    };

    localparam logic [20:0] RAD_PER_TENTH_Q30  = 21'd1874033;
    localparam logic [31:0] HALF_PI_Q30        = 32'd1686629713;
    localparam logic [19:0] GAIN_K_Q20         = 20'd636751;
    localparam logic [25:0] TENTHS_PER_RAD_Q16 = 26'd37549362;
    localparam logic [21:0] DIV1000_MUL        = 22'd2147484;

    localparam logic       CFG_CALM_THRESHOLD = 1'b0;
    localparam logic       CFG_ZONE_OFFSET    = 1'b1;
    localparam logic [7:0] CALM_RESET         = 8'd2;
    localparam logic [4:0] ZONE_RESET         = 5'd2;

    typedef struct packed {
        logic [9:0] ground_speed;
        logic [8:0] course_plus_45;
        logic [8:0] course_minus_45;
        logic [4:0] local_hour;
    } side_t;

endpackage

[rtl/twfaw_pre.sv]
module twfaw_pre #(
    parameter int F  = twfaw_pkg::FRAC_BITS_DEF,
    parameter int W  = F + 15,
    parameter int ZW = F + 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [9:0]           ground_speed,
    input  logic [10:0]          apparent_wind_speed,
    input  logic [11:0]          apparent_wind_angle,
    input  logic [8:0]           true_course,
    input  logic [4:0]           utc_hour,
    input  logic signed [4:0]    zone_offset_hours,
    output logic                 valid_out,
    output logic signed [W-1:0]  x_out,
    output logic signed [W-1:0]  y_out,
    output logic signed [ZW-1:0] z_out,
    output twfaw_pkg::side_t     side_out
);

    localparam int PW = 31 + F + 1;

    logic [11:0]          awa_m;
    logic signed [12:0]   awa_s;
    logic signed [12:0]   awa_f;
    logic                 flip;
    logic [9:0]           awa_abs;
    logic [30:0]          z_prod;
    logic [30:0]          z_rnd;
    logic signed [ZW-1:0] za;
    logic [30:0]          x_prod;
    logic [PW-1:0]        x_sh;
    logic signed [W-1:0]  xa;
    logic [8:0]           course;
    logic [9:0]           cp;
    logic [9:0]           cm;
    logic signed [6:0]    hs;
    logic signed [6:0]    hm;
    twfaw_pkg::side_t     side_next;

    logic                 valid_reg;
    logic signed [W-1:0]  x_reg;
    logic signed [ZW-1:0] z_reg;
    twfaw_pkg::side_t     side_reg;

    always_comb
    begin
        awa_m = (apparent_wind_angle >= 12'd3600) ? apparent_wind_angle - 12'd3600
                                                  : apparent_wind_angle;
        awa_s = (awa_m >= 12'd1800) ? $signed({1'b0, awa_m}) - 13'sd3600
                                    : $signed({1'b0, awa_m});
        flip  = 1'b0;
        awa_f = awa_s;
        if (awa_s > 13'sd900)
        begin
            awa_f = awa_s - 13'sd1800;
            flip  = 1'b1;
        end
        else if (awa_s < -13'sd900)
        begin
            awa_f = awa_s + 13'sd1800;
            flip  = 1'b1;
        end
        awa_abs = awa_f[12] ? 10'(-awa_f) : 10'(awa_f);
        z_prod  = 31'(awa_abs) * 31'(twfaw_pkg::RAD_PER_TENTH_Q30);
        z_rnd   = (z_prod + (31'd1 << (29 - F))) >> (30 - F);
        za      = awa_f[12] ? -$signed(ZW'(z_rnd)) : $signed(ZW'(z_rnd));

        x_prod = 31'(apparent_wind_speed) * 31'(twfaw_pkg::GAIN_K_Q20);
        x_sh   = ((PW'(x_prod) << F) + (PW'(1) << 19)) >> 20;
        xa     = flip ? -$signed(W'(x_sh)) : $signed(W'(x_sh));

        course = (true_course >= 9'd360) ? true_course - 9'd360 : true_course;
        cp     = 10'(course) + 10'd45;
        cm     = 10'(course) + 10'd315;
        hs     = $signed({2'b00, utc_hour}) + 7'(zone_offset_hours);
        if (hs < 7'sd0)
            hm = hs + 7'sd24;
        else if (hs >= 7'sd24)
            hm = hs - 7'sd24;
        else
            hm = hs;

        side_next.ground_speed    = ground_speed;
        side_next.course_plus_45  = (cp >= 10'd360) ? 9'(cp - 10'd360) : 9'(cp);
        side_next.course_minus_45 = (cm >= 10'd360) ? 9'(cm - 10'd360) : 9'(cm);
        side_next.local_hour      = 5'(hm);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= xa;
            z_reg    <= za;
            side_reg <= side_next;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = '0;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

[rtl/twfaw_cordic_stage.sv]
module twfaw_cordic_stage #(
    parameter int F         = twfaw_pkg::FRAC_BITS_DEF,
    parameter int W         = F + 15,
    parameter int ZW        = F + 4,
    parameter int IDX       = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    input  logic signed [ZW-1:0] z_in,
    input  twfaw_pkg::side_t     side_in,
    output logic                 valid_out,
    output logic signed [W-1:0]  x_out,
    output logic signed [W-1:0]  y_out,
    output logic signed [ZW-1:0] z_out,
    output twfaw_pkg::side_t     side_out
);

    localparam logic [63:0] DA64 =
        (64'(twfaw_pkg::ATAN_Q30[IDX]) + (64'd1 << (29 - F))) >> (30 - F);
    localparam logic signed [ZW-1:0] DA = ZW'(DA64);

    logic signed [W-1:0]  dx;
    logic signed [W-1:0]  dy;
    logic                 up;
    logic signed [W-1:0]  x_next;
    logic signed [W-1:0]  y_next;
    logic signed [ZW-1:0] z_next;

    logic                 valid_reg;
    logic signed [W-1:0]  x_reg;
    logic signed [W-1:0]  y_reg;
    logic signed [ZW-1:0] z_reg;
    twfaw_pkg::side_t     side_reg;

    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        // up: x -= dx, y += dy, z -= da
        up = VECTORING ? !(y_in > 0) : (z_in >= 0);
        if (up)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - DA;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + DA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

[rtl/twfaw_post.sv]
module twfaw_post #(
    parameter int F  = twfaw_pkg::FRAC_BITS_DEF,
    parameter int W  = F + 15,
    parameter int ZW = F + 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [ZW-1:0] z_in,
    input  twfaw_pkg::side_t     side_in,
    input  logic [7:0]           calm_threshold,
    output logic                 valid_out,
    output logic [10:0]          true_wind_speed,
    output logic [10:0]          true_wind_angle,
    output twfaw_pkg::side_t     side_out
);

    localparam int MW = W + 20;
    localparam int AW = ZW + 26;

    logic [MW-1:0]        mag_prod;
    logic [W-1:0]         mag_next;
    logic [W-1:0]         kts_full;
    logic [13:0]          kts;
    logic [23:0]          n_next;
    logic [AW-1:0]        ang_prod;
    logic [AW-1:0]        ang_sh;
    logic [45:0]          q_prod;
    logic [13:0]          q;
    logic [10:0]          ms_next;
    logic [10:0]          ang_next;

    logic                 a_valid_reg;
    logic [W-1:0]         a_mag_reg;
    logic signed [ZW-1:0] a_z_reg;
    twfaw_pkg::side_t     a_side_reg;

    logic                 b_valid_reg;
    logic                 b_calm_reg;
    logic                 b_zpos_reg;
    logic [23:0]          b_n_reg;
    logic [13:0]          b_ang_reg;
    twfaw_pkg::side_t     b_side_reg;

    logic                 c_valid_reg;
    logic [10:0]          c_ms_reg;
    logic [10:0]          c_ang_reg;
    twfaw_pkg::side_t     c_side_reg;

    always_comb
    begin
        mag_prod = MW'($unsigned(x_in)) * MW'(twfaw_pkg::GAIN_K_Q20);
        mag_next = (x_in > 0) ? W'((mag_prod + (MW'(1) << 19)) >> 20) : '0;

        kts_full = (a_mag_reg + (W'(1) << (F - 1))) >> F;
        kts      = kts_full[13:0];
        n_next   = 24'(kts) * 24'd514 + 24'd500;
        ang_prod = AW'($unsigned(a_z_reg[ZW-2:0])) * AW'(twfaw_pkg::TENTHS_PER_RAD_Q16);
        ang_sh   = (ang_prod + (AW'(1) << (F + 15))) >> (F + 16);

        q_prod = 46'(b_n_reg) * 46'(twfaw_pkg::DIV1000_MUL);
        q      = q_prod[44:31];
        if (b_calm_reg)
            ms_next = '0;
        else if (q > 14'd2047)
            ms_next = 11'd2047;
        else
            ms_next = q[10:0];
        if (b_calm_reg || !b_zpos_reg)
            ang_next = '0;
        else if (b_ang_reg > 14'd1800)
            ang_next = 11'd1800;
        else
            ang_next = b_ang_reg[10:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= valid_in;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg  <= mag_next;
            a_z_reg    <= z_in;
            a_side_reg <= side_in;
            b_calm_reg <= (kts <= 14'(calm_threshold));
            b_zpos_reg <= (a_z_reg > 0);
            b_n_reg    <= n_next;
            b_ang_reg  <= ang_sh[13:0];
            b_side_reg <= a_side_reg;
            c_ms_reg   <= ms_next;
            c_ang_reg  <= ang_next;
            c_side_reg <= b_side_reg;
        end
    end

    assign valid_out       = c_valid_reg;
    assign true_wind_speed = c_ms_reg;
    assign true_wind_angle = c_ang_reg;
    assign side_out        = c_side_reg;

endmodule

[rtl/true_wind_from_apparent_wind_unit.sv]
// True wind from apparent wind. One transaction in gives one transaction out.
// Fully pipelined: a new sample set is taken every cycle while the output is
// not stalled, and each result passes through the entry stage, rotation
// CORDIC, vector fixup stage, vectoring CORDIC and three output stages. A stall
// on the output holds the whole pipeline; s_tready follows m_tready whenever
// the output register is full. Speed and angle use FRAC_BITS fractional bits
// internally. Configuration writes are only legal while the pipe is empty.
module true_wind_from_apparent_wind_unit #(
    parameter int FRAC_BITS     = twfaw_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = twfaw_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] ground_speed, [20:10] apparent_wind_speed,
    // [32:21] apparent_wind_angle, [41:33] true_course, [46:42] utc_hour
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [10:0] true_wind_speed, [21:11] true_wind_angle,
    // [30:22] course_plus_45, [39:31] course_minus_45, [44:40] local_hour
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_data
);

    localparam int F  = FRAC_BITS;
    localparam int N  = CORDIC_STAGES;
    localparam int W  = F + 15;
    localparam int ZW = F + 4;

    logic              en;
    logic [7:0]        calm_threshold_reg;
    logic signed [4:0] zone_offset_hours_reg;

    logic                 r_valid [N+1];
    logic signed [W-1:0]  r_x     [N+1];
    logic signed [W-1:0]  r_y     [N+1];
    logic signed [ZW-1:0] r_z     [N+1];
    twfaw_pkg::side_t     r_side  [N+1];

    logic                 v_valid [N+1];
    logic signed [W-1:0]  v_x     [N+1];
    logic signed [W-1:0]  v_y     [N+1];
    logic signed [ZW-1:0] v_z     [N+1];
    twfaw_pkg::side_t     v_side  [N+1];

    logic signed [W-1:0]  fx;
    logic signed [W-1:0]  fy_abs;
    logic signed [W-1:0]  fx_next;
    logic signed [W-1:0]  fy_next;
    logic signed [ZW-1:0] fz_next;
    logic                 f_valid_reg;
    logic signed [W-1:0]  f_x_reg;
    logic signed [W-1:0]  f_y_reg;
    logic signed [ZW-1:0] f_z_reg;
    twfaw_pkg::side_t     f_side_reg;

    logic                 o_valid;
    logic [10:0]          o_speed;
    logic [10:0]          o_angle;
    twfaw_pkg::side_t     o_side;

    localparam logic [63:0] HALF_PI64 =
        (64'(twfaw_pkg::HALF_PI_Q30) + (64'd1 << (29 - F))) >> (30 - F);
    localparam logic signed [ZW-1:0] HALF_PI = ZW'(HALF_PI64);

    assign en       = !o_valid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calm_threshold_reg    <= twfaw_pkg::CALM_RESET;
            zone_offset_hours_reg <= twfaw_pkg::ZONE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                twfaw_pkg::CFG_CALM_THRESHOLD: calm_threshold_reg    <= cfg_data;
                twfaw_pkg::CFG_ZONE_OFFSET:    zone_offset_hours_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    twfaw_pre #(.F(F), .W(W), .ZW(ZW)) u_pre (
        .clk                 (clk),
        .rst_n               (rst_n),
        .en                  (en),
        .valid_in            (s_tvalid),
        .ground_speed        (s_tdata[9:0]),
        .apparent_wind_speed (s_tdata[20:10]),
        .apparent_wind_angle (s_tdata[32:21]),
        .true_course         (s_tdata[41:33]),
        .utc_hour            (s_tdata[46:42]),
        .zone_offset_hours   (zone_offset_hours_reg),
        .valid_out           (r_valid[0]),
        .x_out               (r_x[0]),
        .y_out               (r_y[0]),
        .z_out               (r_z[0]),
        .side_out            (r_side[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        twfaw_cordic_stage #(.F(F), .W(W), .ZW(ZW), .IDX(i), .VECTORING(1'b0)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (r_valid[i]),
            .x_in      (r_x[i]),
            .y_in      (r_y[i]),
            .z_in      (r_z[i]),
            .side_in   (r_side[i]),
            .valid_out (r_valid[i+1]),
            .x_out     (r_x[i+1]),
            .y_out     (r_y[i+1]),
            .z_out     (r_z[i+1]),
            .side_out  (r_side[i+1])
        );
    end

    // true wind vector, folded into the right half plane
    always_comb
    begin
        fx     = r_x[N] - (W'(r_side[N].ground_speed) <<< F);
        fy_abs = (r_y[N] < 0) ? -r_y[N] : r_y[N];
        if (fx < 0)
        begin
            fx_next = fy_abs;
            fy_next = -fx;
            fz_next = HALF_PI;
        end
        else
        begin
            fx_next = fx;
            fy_next = fy_abs;
            fz_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (en)
            f_valid_reg <= r_valid[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_x_reg    <= fx_next;
            f_y_reg    <= fy_next;
            f_z_reg    <= fz_next;
            f_side_reg <= r_side[N];
        end
    end

    assign v_valid[0] = f_valid_reg;
    assign v_x[0]     = f_x_reg;
    assign v_y[0]     = f_y_reg;
    assign v_z[0]     = f_z_reg;
    assign v_side[0]  = f_side_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        twfaw_cordic_stage #(.F(F), .W(W), .ZW(ZW), .IDX(i), .VECTORING(1'b1)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (v_valid[i]),
            .x_in      (v_x[i]),
            .y_in      (v_y[i]),
            .z_in      (v_z[i]),
            .side_in   (v_side[i]),
            .valid_out (v_valid[i+1]),
            .x_out     (v_x[i+1]),
            .y_out     (v_y[i+1]),
            .z_out     (v_z[i+1]),
            .side_out  (v_side[i+1])
        );
    end

    twfaw_post #(.F(F), .W(W), .ZW(ZW)) u_post (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .valid_in        (v_valid[N]),
        .x_in            (v_x[N]),
        .z_in            (v_z[N]),
        .side_in         (v_side[N]),
        .calm_threshold  (calm_threshold_reg),
        .valid_out       (o_valid),
        .true_wind_speed (o_speed),
        .true_wind_angle (o_angle),
        .side_out        (o_side)
    );

    assign m_tvalid = o_valid;
    assign m_tdata  = {3'b000, o_side.local_hour, o_side.course_minus_45,
                       o_side.course_plus_45, o_angle, o_speed};

endmodule
